/* rtl/core/nsdf_pkg.sv */
// Shared constants, codes and types for the NSDF pitch estimator.
`timescale 1ns / 1ps
package nsdf_pkg;
  localparam int FRAME_MAX = 1024;
  localparam int FRAME_AW  = $clog2(FRAME_MAX);
  localparam int LEN_W     = FRAME_AW + 1;
  localparam int SMP_W     = 16;
  localparam int NSDF_W    = 17;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int DIV_NW    = 64;
  localparam int DIV_DW    = 48;
  localparam int DIV_CW    = 7;
  localparam int SR_W      = 18;
  localparam int FREQ_W    = 15;
  localparam int THR_W     = 16;
  localparam int PITCH_W   = 26;
  localparam logic [PITCH_W-1:0] PITCH_LIMIT = 26'd49152000;
  localparam int DEN_W     = 21;
  localparam int NUMR_W    = 32;
  localparam int PP_W      = 46;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 18;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_FREQ    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_FREQ    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FRAME_SIZE  = 3'd4;

  localparam logic [1:0] DIV_SR_FMAX = 2'd0;
  localparam logic [1:0] DIV_SR_FMIN = 2'd1;
  localparam logic [1:0] DIV_NSDF    = 2'd2;
  localparam logic [1:0] DIV_PITCH   = 2'd3;

  localparam logic [1:0] REF_LEFT  = 2'd0;
  localparam logic [1:0] REF_MID   = 2'd1;
  localparam logic [1:0] REF_RIGHT = 2'd2;

  typedef struct packed {
    logic       smp_wr;
    logic       fill_clr;
    logic       div_start;
    logic [1:0] div_sel;
    logic       lag_min_ld;
    logic       lag_max_ld;
    logic       tau_clr;
    logic       tau_inc;
    logic       mac_clr;
    logic       mac_issue;
    logic       nsdf_wr;
    logic       scan_init;
    logic       scan_ev;
    logic       ref_rd;
    logic [1:0] ref_sel;
    logic       cap_s0;
    logic       cap_s1;
    logic       cap_s2;
    logic       calc;
    logic       pq_plain;
    logic       pq_ref;
    logic       res_none;
    logic       res_pitch;
  } nsdf_cmd_t;

  typedef struct packed {
    logic last_smp;
    logic div_done;
    logic lag_empty;
    logic mac_more;
    logic pipe_busy;
    logic tau_last;
    logic scan_done;
    logic best_none;
    logic refine;
    logic rden_zero;
    logic bad;
  } nsdf_sts_t;
endpackage

/* rtl/core/nsdf_pitch_estimator.sv */
// Top level of the NSDF pitch estimator: configuration registers, controller and datapath.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | start, busy, in_sample                  | taken when start & !busy
//  result  | out_valid, out_pitch_q8, out_found      | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when valid & ready
//
// A sample that does not close a frame is only stored and busy stays low. The closing
// sample starts the analysis: two lag divides, then per lag a pass over N - tau sample
// pairs on the shared MAC plus an NSDF divide, a peak scan, parabolic refinement if
// taken and a pitch divide; busy stays high throughout and the result strobes once.
// Reset (rst_n low, synchronous) empties the frame and restores the register defaults.
// The result is never stalled; cfg_ready is always high.
`timescale 1ns / 1ps
module nsdf_pitch_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [nsdf_pkg::SMP_W-1:0]   in_sample,
  output logic                                out_valid,
  output logic [nsdf_pkg::PITCH_W-1:0]        out_pitch_q8,
  output logic                                out_found,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nsdf_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [nsdf_pkg::CFG_DW-1:0]         cfg_data
);
  logic [nsdf_pkg::SR_W-1:0]         sample_rate_r;
  logic [nsdf_pkg::FREQ_W-1:0]       min_freq_r;
  logic [nsdf_pkg::FREQ_W-1:0]       max_freq_r;
  logic signed [nsdf_pkg::THR_W-1:0] threshold_r;
  logic [nsdf_pkg::LEN_W-1:0]        frame_size_r;
  nsdf_pkg::nsdf_cmd_t               cmd;
  nsdf_pkg::nsdf_sts_t               sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= nsdf_pkg::SR_W'(48000);
      min_freq_r    <= nsdf_pkg::FREQ_W'(50);
      max_freq_r    <= nsdf_pkg::FREQ_W'(1000);
      threshold_r   <= nsdf_pkg::THR_W'(29491);
      frame_size_r  <= nsdf_pkg::LEN_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        nsdf_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_data;
        nsdf_pkg::REG_MIN_FREQ:    min_freq_r    <= cfg_data[nsdf_pkg::FREQ_W-1:0];
        nsdf_pkg::REG_MAX_FREQ:    max_freq_r    <= cfg_data[nsdf_pkg::FREQ_W-1:0];
        nsdf_pkg::REG_THRESHOLD:   threshold_r   <= cfg_data[nsdf_pkg::THR_W-1:0];
        nsdf_pkg::REG_FRAME_SIZE:  frame_size_r  <= cfg_data[nsdf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  nsdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  nsdf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_sample),
    .sample_rate  (sample_rate_r),
    .min_freq     (min_freq_r),
    .max_freq     (max_freq_r),
    .threshold    (threshold_r),
    .frame_size   (frame_size_r),
    .out_valid    (out_valid),
    .out_pitch_q8 (out_pitch_q8),
    .out_found    (out_found)
  );
endmodule

/* rtl/core/nsdf_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nsdf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nsdf_pkg::DIV_NW-1:0]   num,
  input  logic [nsdf_pkg::DIV_DW-1:0]   den,
  output logic                          done,
  output logic [nsdf_pkg::DIV_NW-1:0]   quot
);
  logic [nsdf_pkg::DIV_DW:0]   rem_r;
  logic [nsdf_pkg::DIV_DW-1:0] den_r;
  logic [nsdf_pkg::DIV_NW-1:0] quo_r;
  logic [nsdf_pkg::DIV_CW-1:0] cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [nsdf_pkg::DIV_DW:0]   trial;
  logic                        ge;

  assign trial = {rem_r[nsdf_pkg::DIV_DW-1:0], quo_r[nsdf_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nsdf_pkg::DIV_CW'(nsdf_pkg::DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
      quo_r <= {quo_r[nsdf_pkg::DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

/* rtl/core/nsdf_dp.sv */
// Datapath: sample and NSDF stores, MAC pipeline, divider, peak scan and refinement.
`timescale 1ns / 1ps
module nsdf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nsdf_pkg::nsdf_cmd_t                 cmd,
  output nsdf_pkg::nsdf_sts_t                 sts,
  input  logic signed [nsdf_pkg::SMP_W-1:0]   in_sample,
  input  logic [nsdf_pkg::SR_W-1:0]           sample_rate,
  input  logic [nsdf_pkg::FREQ_W-1:0]         min_freq,
  input  logic [nsdf_pkg::FREQ_W-1:0]         max_freq,
  input  logic signed [nsdf_pkg::THR_W-1:0]   threshold,
  input  logic [nsdf_pkg::LEN_W-1:0]          frame_size,
  output logic                                out_valid,
  output logic [nsdf_pkg::PITCH_W-1:0]        out_pitch_q8,
  output logic                                out_found
);
  localparam int AW = nsdf_pkg::FRAME_AW;
  localparam int LW = nsdf_pkg::LEN_W;
  localparam int NW = nsdf_pkg::NSDF_W;

  logic signed [nsdf_pkg::SMP_W-1:0] frame_mem [nsdf_pkg::FRAME_MAX];
  logic signed [NW-1:0]              nsdf_mem  [nsdf_pkg::FRAME_MAX];

  logic [LW-1:0] n_w;
  logic [LW-1:0] fill_r;

  // divider
  logic                          div_done;
  logic [nsdf_pkg::DIV_NW-1:0]   div_quot;
  logic [nsdf_pkg::DIV_NW-1:0]   div_num;
  logic [nsdf_pkg::DIV_DW-1:0]   div_den;

  // lags
  logic [nsdf_pkg::SR_W-1:0] min_tau_r;
  logic [AW-1:0]             max_tau_r;
  logic [nsdf_pkg::SR_W-1:0] q_lag;

  // mac
  logic [AW-1:0]                       tau_r;
  logic [LW-1:0]                       j_r;
  logic [LW-1:0]                       cnt_w;
  logic [LW-1:0]                       jb_w;
  logic                                v1_r, v2_r;
  logic signed [nsdf_pkg::SMP_W-1:0]   ra_r, rb_r;
  logic signed [nsdf_pkg::PROD_W-1:0]  pab_r, paa_r, pbb_r;
  logic signed [nsdf_pkg::ACC_W-1:0]   cross_r, he_r, te_r;
  logic [nsdf_pkg::ACC_W-1:0]          energy;
  logic signed [nsdf_pkg::ACC_W:0]     num2;
  logic [nsdf_pkg::ACC_W:0]            mag;
  logic [NW-1:0]                       qn;
  logic signed [NW-1:0]                nsdf_val;

  // scan
  logic [AW-1:0]        k_r;
  logic [AW-1:0]        nraddr;
  logic signed [NW-1:0] nrd_r;
  logic signed [NW-1:0] prev_r, bestv_r;
  logic [AW-1:0]        best_r;
  logic                 in_peak_r, has_best_r;
  logic                 brk, ip_n, upd;
  logic signed [NW-1:0] thr_x;

  // refinement
  logic signed [NW-1:0]               s0_r, s1_r, s2_r;
  logic signed [nsdf_pkg::DEN_W-1:0]  den_r, den_w, absden;
  logic signed [nsdf_pkg::NUMR_W-1:0] numr_r, numr_w, absnumr;
  logic [nsdf_pkg::PP_W-1:0]          p_r;
  logic [nsdf_pkg::NUMR_W-1:0]        q_r;
  logic [37:0]                        prod_sr;

  logic                          outv_r;
  logic [nsdf_pkg::PITCH_W-1:0]  pitch_r;
  logic                          found_r;

  function automatic logic signed [nsdf_pkg::DEN_W-1:0] DEN_W_calc(
      input logic signed [NW-1:0] a, input logic signed [NW-1:0] b,
      input logic signed [NW-1:0] c);
    logic signed [nsdf_pkg::DEN_W-1:0] t;
    t = nsdf_pkg::DEN_W'(a) - (nsdf_pkg::DEN_W'(b) <<< 1) + nsdf_pkg::DEN_W'(c);
    return t <<< 1;
  endfunction

  always_comb begin
    if (frame_size < LW'(2)) n_w = LW'(2);
    else if (frame_size > LW'(nsdf_pkg::FRAME_MAX)) n_w = LW'(nsdf_pkg::FRAME_MAX);
    else n_w = frame_size;
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.smp_wr) begin
      fill_r <= cmd.fill_clr ? '0 : fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_wr) frame_mem[fill_r[AW-1:0]] <= in_sample;
  end

  // divider operands
  assign energy = he_r + te_r;
  assign num2   = {cross_r, 1'b0};
  assign mag    = num2[nsdf_pkg::ACC_W] ? -num2 : num2;

  always_comb begin
    case (cmd.div_sel)
      nsdf_pkg::DIV_SR_FMAX: begin
        div_num = nsdf_pkg::DIV_NW'(sample_rate);
        div_den = (max_freq == '0) ? nsdf_pkg::DIV_DW'(1) : nsdf_pkg::DIV_DW'(max_freq);
      end
      nsdf_pkg::DIV_SR_FMIN: begin
        div_num = nsdf_pkg::DIV_NW'(sample_rate);
        div_den = (min_freq == '0) ? nsdf_pkg::DIV_DW'(1) : nsdf_pkg::DIV_DW'(min_freq);
      end
      nsdf_pkg::DIV_NSDF: begin
        div_num = {mag, 15'd0} + nsdf_pkg::DIV_NW'(energy >> 1);
        div_den = energy;
      end
      default: begin
        div_num = nsdf_pkg::DIV_NW'(p_r) + nsdf_pkg::DIV_NW'(q_r >> 1);
        div_den = nsdf_pkg::DIV_DW'(q_r);
      end
    endcase
  end

  nsdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // lag limits
  assign q_lag = div_quot[nsdf_pkg::SR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.lag_min_ld) min_tau_r <= (q_lag == '0) ? nsdf_pkg::SR_W'(1) : q_lag;
    if (cmd.lag_max_ld) begin
      if (q_lag >= nsdf_pkg::SR_W'(n_w)) max_tau_r <= AW'(n_w - 1'b1);
      else max_tau_r <= q_lag[AW-1:0];
    end
  end

  // MAC pipeline: address, read, multiply, accumulate
  assign cnt_w = n_w - LW'(tau_r);
  assign jb_w  = j_r + LW'(tau_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tau_clr) tau_r <= '0;
    else if (cmd.tau_inc) tau_r <= tau_r + 1'b1;
    if (cmd.mac_clr) j_r <= '0;
    else if (cmd.mac_issue) j_r <= j_r + 1'b1;
    ra_r  <= frame_mem[j_r[AW-1:0]];
    rb_r  <= frame_mem[jb_w[AW-1:0]];
    pab_r <= ra_r * rb_r;
    paa_r <= ra_r * ra_r;
    pbb_r <= rb_r * rb_r;
    if (cmd.mac_clr) begin
      cross_r <= '0;
      he_r    <= '0;
      te_r    <= '0;
    end else if (v2_r) begin
      cross_r <= cross_r + nsdf_pkg::ACC_W'(pab_r);
      he_r    <= he_r + nsdf_pkg::ACC_W'(paa_r);
      te_r    <= te_r + nsdf_pkg::ACC_W'(pbb_r);
    end
  end

  assign qn       = div_quot[NW-1:0];
  assign nsdf_val = (energy == '0) ? '0 : (num2[nsdf_pkg::ACC_W] ? -qn : qn);

  always_ff @(posedge clk) begin
    if (cmd.nsdf_wr) nsdf_mem[tau_r] <= nsdf_val;
  end

  // peak scan
  always_comb begin
    case (cmd.ref_sel)
      nsdf_pkg::REF_LEFT:  nraddr = best_r - 1'b1;
      nsdf_pkg::REF_MID:   nraddr = best_r;
      nsdf_pkg::REF_RIGHT: nraddr = best_r + 1'b1;
      default:             nraddr = best_r;
    endcase
    if (!cmd.ref_rd) nraddr = k_r;
  end

  always_ff @(posedge clk) begin
    nrd_r <= nsdf_mem[nraddr];
  end

  assign thr_x = NW'(threshold);
  assign brk   = (k_r != min_tau_r[AW-1:0]) && in_peak_r && (nrd_r < prev_r);
  assign ip_n  = in_peak_r || (nrd_r > thr_x);
  assign upd   = !brk && ip_n && (!has_best_r || nrd_r > bestv_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      k_r        <= min_tau_r[AW-1:0];
      in_peak_r  <= 1'b0;
      has_best_r <= 1'b0;
    end else if (cmd.scan_ev) begin
      k_r    <= k_r + 1'b1;
      prev_r <= nrd_r;
      if (!brk) in_peak_r <= ip_n;
      if (upd) begin
        has_best_r <= 1'b1;
        best_r     <= k_r;
        bestv_r    <= nrd_r;
      end
    end
  end

  // parabolic refinement
  assign den_w   = DEN_W_calc(s0_r, s1_r, s2_r);
  assign numr_w  = nsdf_pkg::NUMR_W'($signed({1'b0, best_r})) * nsdf_pkg::NUMR_W'(den_r)
                   + nsdf_pkg::NUMR_W'(s0_r) - nsdf_pkg::NUMR_W'(s2_r);
  assign absden  = den_r[nsdf_pkg::DEN_W-1] ? -den_r : den_r;
  assign absnumr = numr_r[nsdf_pkg::NUMR_W-1] ? -numr_r : numr_r;
  assign prod_sr = 38'(sample_rate) * 38'(absden[nsdf_pkg::DEN_W-2:0]);

  always_ff @(posedge clk) begin
    if (cmd.cap_s0) s0_r <= nrd_r;
    if (cmd.cap_s1) s1_r <= nrd_r;
    if (cmd.cap_s2) s2_r <= nrd_r;
    if (cmd.calc) begin
      den_r  <= den_w;
      numr_r <= numr_w;
    end
    // numr_w uses den_r; calc is issued twice so the second pass sees the fresh den_r
    if (cmd.pq_plain) begin
      p_r <= nsdf_pkg::PP_W'({sample_rate, 8'd0});
      q_r <= nsdf_pkg::NUMR_W'(best_r);
    end else if (cmd.pq_ref) begin
      p_r <= {prod_sr, 8'd0};
      q_r <= absnumr;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else begin
      outv_r <= cmd.res_none || cmd.res_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_none) begin
      pitch_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.res_pitch) begin
      found_r <= 1'b1;
      if (div_quot > nsdf_pkg::DIV_NW'(nsdf_pkg::PITCH_LIMIT)) pitch_r <= nsdf_pkg::PITCH_LIMIT;
      else pitch_r <= div_quot[nsdf_pkg::PITCH_W-1:0];
    end
  end

  assign out_valid    = outv_r;
  assign out_pitch_q8 = pitch_r;
  assign out_found    = found_r;

  assign sts.last_smp  = (fill_r + 1'b1) >= n_w;
  assign sts.div_done  = div_done;
  assign sts.lag_empty = nsdf_pkg::SR_W'(max_tau_r) < min_tau_r;
  assign sts.mac_more  = j_r < cnt_w;
  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.tau_last  = tau_r == max_tau_r;
  assign sts.scan_done = brk || (k_r == max_tau_r);
  assign sts.best_none = !has_best_r;
  assign sts.refine    = best_r < max_tau_r;
  assign sts.rden_zero = den_r == '0;
  assign sts.bad       = (numr_r == '0) ||
                         (numr_r[nsdf_pkg::NUMR_W-1] != den_r[nsdf_pkg::DEN_W-1]);
endmodule

/* rtl/core/nsdf_ctrl.sv */
// Controller state machine sequencing capture, NSDF, scan and refinement.
`timescale 1ns / 1ps
module nsdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  nsdf_pkg::nsdf_sts_t  sts,
  output nsdf_pkg::nsdf_cmd_t  cmd
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIV1   = 5'd1;
  localparam logic [4:0] S_DIV2   = 5'd2;
  localparam logic [4:0] S_CHK    = 5'd3;
  localparam logic [4:0] S_MAC    = 5'd4;
  localparam logic [4:0] S_DRAIN  = 5'd5;
  localparam logic [4:0] S_NDIV   = 5'd6;
  localparam logic [4:0] S_SRD    = 5'd7;
  localparam logic [4:0] S_SEV    = 5'd8;
  localparam logic [4:0] S_BEST   = 5'd9;
  localparam logic [4:0] S_R1     = 5'd10;
  localparam logic [4:0] S_R2     = 5'd11;
  localparam logic [4:0] S_R3     = 5'd12;
  localparam logic [4:0] S_R4     = 5'd13;
  localparam logic [4:0] S_R5     = 5'd14;
  localparam logic [4:0] S_R6     = 5'd15;
  localparam logic [4:0] S_PSTART = 5'd16;
  localparam logic [4:0] S_PDIV   = 5'd17;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.smp_wr = 1'b1;
          if (sts.last_smp) begin
            cmd.fill_clr  = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = nsdf_pkg::DIV_SR_FMAX;
            state_nxt     = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.lag_min_ld = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = nsdf_pkg::DIV_SR_FMIN;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.lag_max_ld = 1'b1;
          state_nxt      = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.lag_empty) begin
          cmd.res_none = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.tau_clr = 1'b1;
          cmd.mac_clr = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        if (sts.mac_more) cmd.mac_issue = 1'b1;
        else state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = nsdf_pkg::DIV_NSDF;
          state_nxt     = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd.div_sel = nsdf_pkg::DIV_NSDF;
        if (sts.div_done) begin
          cmd.nsdf_wr = 1'b1;
          if (sts.tau_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SRD;
          end else begin
            cmd.tau_inc = 1'b1;
            cmd.mac_clr = 1'b1;
            state_nxt   = S_MAC;
          end
        end
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = sts.scan_done ? S_BEST : S_SRD;
      end
      S_BEST: begin
        if (sts.best_none) begin
          cmd.res_none = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.refine) begin
          cmd.ref_rd  = 1'b1;
          cmd.ref_sel = nsdf_pkg::REF_LEFT;
          state_nxt   = S_R1;
        end else begin
          cmd.pq_plain = 1'b1;
          state_nxt    = S_PSTART;
        end
      end
      S_R1: begin
        cmd.ref_rd  = 1'b1;
        cmd.ref_sel = nsdf_pkg::REF_MID;
        cmd.cap_s0  = 1'b1;
        state_nxt   = S_R2;
      end
      S_R2: begin
        cmd.ref_rd  = 1'b1;
        cmd.ref_sel = nsdf_pkg::REF_RIGHT;
        cmd.cap_s1  = 1'b1;
        state_nxt   = S_R3;
      end
      S_R3: begin
        cmd.cap_s2 = 1'b1;
        state_nxt  = S_R4;
      end
      S_R4: begin
        cmd.calc  = 1'b1;
        state_nxt = S_R5;
      end
      S_R5: begin
        cmd.calc  = 1'b1;
        state_nxt = S_R6;
      end
      S_R6: begin
        if (sts.rden_zero) begin
          cmd.pq_plain = 1'b1;
          state_nxt    = S_PSTART;
        end else if (sts.bad) begin
          cmd.res_none = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.pq_ref = 1'b1;
          state_nxt  = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = nsdf_pkg::DIV_PITCH;
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_sel = nsdf_pkg::DIV_PITCH;
        if (sts.div_done) begin
          cmd.res_pitch = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
